[sv/jad_pkg.sv]
// Shared constants, tables and types for the joystick heading pipeline.
package jad_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int CORDIC_STAGES_DEF = 20;

    localparam int DEAD_W    = 12;
    localparam int LIMIT_W   = 15;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 3;
    localparam int MAG_W     = 15;
    localparam int AXIS_W    = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_DEAD_LOW  = 3'd0,
        REG_X_DEAD_HIGH = 3'd1,
        REG_Y_DEAD_LOW  = 3'd2,
        REG_Y_DEAD_HIGH = 3'd3,
        REG_CLAMP_LIMIT = 3'd4
    } reg_idx_t;

    localparam logic [DEAD_W-1:0]  X_DEAD_LOW_RST  = 12'hFD8;  // -40
    localparam logic [DEAD_W-1:0]  X_DEAD_HIGH_RST = 12'd41;
    localparam logic [DEAD_W-1:0]  Y_DEAD_LOW_RST  = 12'hFE4;  // -28
    localparam logic [DEAD_W-1:0]  Y_DEAD_HIGH_RST = 12'd29;
    localparam logic [LIMIT_W-1:0] CLAMP_LIMIT_RST = 15'd1820;

    // angles: radians, 30 fractional bits
    localparam int ANG_FRAC = 30;
    localparam int XY_W     = MAG_W + ANG_FRAC + 3;
    localparam int ANG_W    = 32;
    localparam int OCT_W    = 30;
    localparam int ATAN_N   = 32;

    localparam logic [ANG_W-1:0] ANG_PI      = 32'd3373259426;
    localparam logic [ANG_W-1:0] ANG_HALF_PI = 32'd1686629713;

    localparam logic [OCT_W-1:0] ATAN_TAB [ATAN_N] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,
        30'd64,        30'd32,        30'd16,        30'd8,
        30'd4,         30'd2,         30'd1,         30'd0
    };
    localparam logic [OCT_W-1:0] OCT_MAX = 30'd843314856;

    // degrees = r * 18000000 / (314159 << 30)
    localparam int DNUM_W = 25;
    localparam int PROD_W = ANG_W + DNUM_W;
    localparam int T_W    = PROD_W - ANG_FRAC;
    localparam int DEN_W  = 19;
    localparam logic [DNUM_W-1:0] DEG_NUM = 25'd18000000;
    localparam logic [DEN_W-1:0]  DEG_DEN = 19'd314159;

    localparam int RECIP_SHIFT = 48;
    localparam int RECIP_W     = 30;
    localparam longint unsigned RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'd314159;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam int QM_W  = T_W + RECIP_W;
    localparam int Q_W   = 8;
    localparam int REM_W = DEN_W + 1;

    localparam int HEAD_W     = 9;
    localparam int OUT_DATA_W = 16;
    localparam logic [HEAD_W-1:0] FULL_TURN = 9'd360;
    localparam logic [HEAD_W-1:0] HEAD_MAX  = 9'd359;

    typedef struct packed {
        logic zero;        // both axes zero
        logic neg_x;
        logic neg_y;
        logic swap;        // |x| > |y|
        logic minor_zero;
        logic equal;       // |x| == |y|
    } side_t;

endpackage

[sv/joystick_angle_degrees_unit.sv]
// Throughput: one beat per cycle; each stage stalls only when it is full and
// the stage after it cannot take its beat, so bubbles are squeezed out.
// Pipeline depth grows with the CORDIC rotation stages, one rotation per stage.
// Reset clears all valid bits and loads the dead-zone and clamp registers
// with their default values.
module joystick_angle_degrees_unit
    import jad_pkg::*;
#(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    localparam int IN_DATA_W    = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // pos_x, pos_y
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // heading_deg
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    logic [DEAD_W-1:0]  x_dead_low_reg;
    logic [DEAD_W-1:0]  x_dead_high_reg;
    logic [DEAD_W-1:0]  y_dead_low_reg;
    logic [DEAD_W-1:0]  y_dead_high_reg;
    logic [LIMIT_W-1:0] clamp_limit_reg;

    logic                    cond_valid;
    logic                    cond_ready;
    logic [MAG_W-1:0]        cond_major;
    logic [MAG_W-1:0]        cond_minor;
    side_t                   cond_side;
    logic                    cordic_valid;
    logic                    cordic_ready;
    logic signed [ANG_W-1:0] cordic_angle;
    side_t                   cordic_side;
    logic [HEAD_W-1:0]       heading_deg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_dead_low_reg  <= X_DEAD_LOW_RST;
            x_dead_high_reg <= X_DEAD_HIGH_RST;
            y_dead_low_reg  <= Y_DEAD_LOW_RST;
            y_dead_high_reg <= Y_DEAD_HIGH_RST;
            clamp_limit_reg <= CLAMP_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_X_DEAD_LOW:  x_dead_low_reg  <= cfg_data[DEAD_W-1:0];
                REG_X_DEAD_HIGH: x_dead_high_reg <= cfg_data[DEAD_W-1:0];
                REG_Y_DEAD_LOW:  y_dead_low_reg  <= cfg_data[DEAD_W-1:0];
                REG_Y_DEAD_HIGH: y_dead_high_reg <= cfg_data[DEAD_W-1:0];
                REG_CLAMP_LIMIT: clamp_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    jad_condition #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_condition (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .pos_x       (s_tdata[SAMPLE_WIDTH-1:0]),
        .pos_y       (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .x_dead_low  (x_dead_low_reg),
        .x_dead_high (x_dead_high_reg),
        .y_dead_low  (y_dead_low_reg),
        .y_dead_high (y_dead_high_reg),
        .clamp_limit (clamp_limit_reg),
        .out_valid   (cond_valid),
        .out_ready   (cond_ready),
        .major       (cond_major),
        .minor       (cond_minor),
        .side        (cond_side)
    );

    jad_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cond_valid),
        .in_ready  (cond_ready),
        .major     (cond_major),
        .minor     (cond_minor),
        .side_in   (cond_side),
        .out_valid (cordic_valid),
        .out_ready (cordic_ready),
        .angle     (cordic_angle),
        .side_out  (cordic_side)
    );

    jad_degrees u_degrees (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cordic_valid),
        .in_ready  (cordic_ready),
        .angle     (cordic_angle),
        .side      (cordic_side),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .heading   (heading_deg)
    );

    assign m_tdata = {{(OUT_DATA_W-HEAD_W){1'b0}}, heading_deg};

`ifndef ASSERT_OFF
    // an empty output stage frees every stage behind it
    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage empty");

    a_sink_ready_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while sink ready");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[HEAD_W-1:0] <= HEAD_MAX))
        else $error("heading out of range");
`endif

endmodule

[sv/jad_condition.sv]
// Dead-zone, clamp and octant fold of one stick sample (two stages).
module jad_condition
    import jad_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [SAMPLE_WIDTH-1:0] pos_x,
    input  logic [SAMPLE_WIDTH-1:0] pos_y,
    input  logic [DEAD_W-1:0]       x_dead_low,
    input  logic [DEAD_W-1:0]       x_dead_high,
    input  logic [DEAD_W-1:0]       y_dead_low,
    input  logic [DEAD_W-1:0]       y_dead_high,
    input  logic [LIMIT_W-1:0]      clamp_limit,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [MAG_W-1:0]        major,
    output logic [MAG_W-1:0]        minor,
    output side_t                   side
);

    localparam int CMP_W = (SAMPLE_WIDTH + 1 > AXIS_W) ? SAMPLE_WIDTH + 1 : AXIS_W;

    function automatic logic [AXIS_W-1:0] condition_axis(
        input logic [SAMPLE_WIDTH-1:0] v,
        input logic [DEAD_W-1:0]       lo,
        input logic [DEAD_W-1:0]       hi,
        input logic [LIMIT_W-1:0]      lim
    );
        logic signed [CMP_W-1:0] vs;
        logic signed [CMP_W-1:0] los;
        logic signed [CMP_W-1:0] his;
        logic signed [CMP_W-1:0] lims;
        logic signed [CMP_W-1:0] r;
        vs   = $signed({{(CMP_W-SAMPLE_WIDTH){v[SAMPLE_WIDTH-1]}}, v});
        los  = $signed({{(CMP_W-DEAD_W){lo[DEAD_W-1]}}, lo});
        his  = $signed({{(CMP_W-DEAD_W){hi[DEAD_W-1]}}, hi});
        lims = $signed({{(CMP_W-LIMIT_W){1'b0}}, lim});
        r = vs;
        if (vs > los && vs < his)
            r = '0;
        if (r > lims)
            r = lims;
        if (r < -lims)
            r = -lims;
        return r[AXIS_W-1:0];
    endfunction

    logic [1:0] v_reg;
    logic [2:0] en;

    logic signed [AXIS_W-1:0] xc_reg;
    logic signed [AXIS_W-1:0] yc_reg;
    logic [MAG_W-1:0]         major_reg;
    logic [MAG_W-1:0]         minor_reg;
    side_t                    side_reg;

    logic signed [AXIS_W-1:0] ax_full;
    logic signed [AXIS_W-1:0] ay_full;
    logic [MAG_W-1:0]         ax;
    logic [MAG_W-1:0]         ay;
    logic [MAG_W-1:0]         major_next;
    logic [MAG_W-1:0]         minor_next;
    side_t                    side_next;

    assign en[2]    = out_ready;
    assign en[1]    = !v_reg[1] || en[2];
    assign en[0]    = !v_reg[0] || en[1];
    assign in_ready = en[0];

    always_comb
    begin
        ax_full = xc_reg[AXIS_W-1] ? -xc_reg : xc_reg;
        ay_full = yc_reg[AXIS_W-1] ? -yc_reg : yc_reg;
        ax = ax_full[MAG_W-1:0];
        ay = ay_full[MAG_W-1:0];
        side_next.swap  = ax > ay;
        major_next      = side_next.swap ? ax : ay;
        minor_next      = side_next.swap ? ay : ax;
        side_next.zero  = (ax == '0) && (ay == '0);
        side_next.neg_x = xc_reg[AXIS_W-1];
        side_next.neg_y = yc_reg[AXIS_W-1];
        side_next.minor_zero = minor_next == '0;
        side_next.equal      = minor_next == major_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            if (en[1])
                v_reg[1] <= v_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            xc_reg <= condition_axis(pos_x, x_dead_low, x_dead_high, clamp_limit);
            yc_reg <= condition_axis(pos_y, y_dead_low, y_dead_high, clamp_limit);
        end
        if (en[1])
        begin
            major_reg <= major_next;
            minor_reg <= minor_next;
            side_reg  <= side_next;
        end
    end

    assign out_valid = v_reg[1];
    assign major     = major_reg;
    assign minor     = minor_reg;
    assign side      = side_reg;

endmodule

[sv/jad_cordic.sv]
// Vectoring CORDIC, one rotation per register stage.
module jad_cordic
    import jad_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [MAG_W-1:0]        major,
    input  logic [MAG_W-1:0]        minor,
    input  side_t                   side_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [ANG_W-1:0] angle,
    output side_t                   side_out
);

    localparam int N = CORDIC_STAGES;

    logic [N-1:0] v_reg;
    logic [N:0]   en;

    logic signed [XY_W-1:0]  x_reg [N];
    logic signed [XY_W-1:0]  y_reg [N];
    logic signed [ANG_W-1:0] z_reg [N];
    side_t                   s_reg [N];

    logic signed [XY_W-1:0] x_in;
    logic signed [XY_W-1:0] y_in;

    assign x_in = $signed({{(XY_W-MAG_W-ANG_FRAC){1'b0}}, major, {ANG_FRAC{1'b0}}});
    assign y_in = $signed({{(XY_W-MAG_W-ANG_FRAC){1'b0}}, minor, {ANG_FRAC{1'b0}}});

    assign en[N]    = out_ready;
    assign in_ready = en[0];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic signed [XY_W-1:0]  x_prev;
        logic signed [XY_W-1:0]  y_prev;
        logic signed [ANG_W-1:0] z_prev;
        side_t                   s_prev;
        logic                    v_prev;
        logic signed [ANG_W-1:0] step;

        if (i == 0)
        begin : g_first
            assign x_prev = x_in;
            assign y_prev = y_in;
            assign z_prev = '0;
            assign s_prev = side_in;
            assign v_prev = in_valid;
        end
        else
        begin : g_next
            assign x_prev = x_reg[i-1];
            assign y_prev = y_reg[i-1];
            assign z_prev = z_reg[i-1];
            assign s_prev = s_reg[i-1];
            assign v_prev = v_reg[i-1];
        end

        assign step  = $signed({{(ANG_W-OCT_W){1'b0}}, ATAN_TAB[i]});
        assign en[i] = !v_reg[i] || en[i+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en[i])
                v_reg[i] <= v_prev;
        end

        // rotate toward the x axis; >>> floors the shifted value
        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                if (!y_prev[XY_W-1])
                begin
                    x_reg[i] <= x_prev + (y_prev >>> i);
                    y_reg[i] <= y_prev - (x_prev >>> i);
                    z_reg[i] <= z_prev + step;
                end
                else
                begin
                    x_reg[i] <= x_prev - (y_prev >>> i);
                    y_reg[i] <= y_prev + (x_prev >>> i);
                    z_reg[i] <= z_prev - step;
                end
                s_reg[i] <= s_prev;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign angle     = z_reg[N-1];
    assign side_out  = s_reg[N-1];

endmodule

[sv/jad_degrees.sv]
// Octant unfold and radians-to-degrees conversion (five stages).
module jad_degrees
    import jad_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [ANG_W-1:0] angle,
    input  side_t                   side,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [HEAD_W-1:0]       heading
);

    localparam int NS = 5;

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    // stage 1
    logic [ANG_W-1:0]  r_reg;
    logic              neg_x1_reg;
    logic              zero1_reg;
    // stage 2
    logic [PROD_W-1:0] prod_reg;
    logic              neg_x2_reg;
    logic              zero2_reg;
    // stage 3
    logic [T_W-1:0]    t_reg;
    logic [Q_W-1:0]    q0_reg;
    logic              frac3_reg;
    logic              neg_x3_reg;
    logic              zero3_reg;
    // stage 4
    logic [REM_W-1:0]  rem_reg;
    logic [Q_W-1:0]    q4_reg;
    logic              frac4_reg;
    logic              neg_x4_reg;
    logic              zero4_reg;
    // stage 5
    logic [HEAD_W-1:0] head_reg;

    logic [OCT_W-1:0]  oct;
    logic [ANG_W-1:0]  theta;
    logic [ANG_W-1:0]  r_next;
    logic [QM_W-1:0]   qm;
    logic [REM_W-1:0]  rem_next;
    logic [Q_W-1:0]    q_fix;
    logic [REM_W-1:0]  rem_fix;
    logic              exact;
    logic [HEAD_W-1:0] ceil_q;
    logic [HEAD_W-1:0] head_next;

    assign en[NS]   = out_ready;
    assign in_ready = en[0];
    for (genvar i = 0; i < NS; i++)
    begin : g_en
        assign en[i] = !v_reg[i] || en[i+1];
    end

    always_comb
    begin
        // exact axes and diagonals bypass the CORDIC residue
        if (side.minor_zero)
            oct = '0;
        else if (side.equal)
            oct = ATAN_TAB[0];
        else if (angle < 32'sd1)
            oct = OCT_W'(1);
        else if (angle > $signed({{(ANG_W-OCT_W){1'b0}}, OCT_MAX}))
            oct = OCT_MAX;
        else
            oct = angle[OCT_W-1:0];
        theta  = side.swap ? ANG_HALF_PI - {{(ANG_W-OCT_W){1'b0}}, oct}
                           : {{(ANG_W-OCT_W){1'b0}}, oct};
        r_next = side.neg_y ? ANG_PI - theta : theta;
    end

    // quotient estimate straight from the product, remainder one stage later
    assign qm       = prod_reg[PROD_W-1:ANG_FRAC] * RECIP;
    assign rem_next = REM_W'(t_reg - T_W'(q0_reg * DEG_DEN));

    // reciprocal estimate is low by at most one
    always_comb
    begin
        if (rem_reg >= {1'b0, DEG_DEN})
        begin
            q_fix   = q4_reg + 1'b1;
            rem_fix = rem_reg - {1'b0, DEG_DEN};
        end
        else
        begin
            q_fix   = q4_reg;
            rem_fix = rem_reg;
        end
        exact  = !frac4_reg && (rem_fix == '0);
        ceil_q = {{(HEAD_W-Q_W){1'b0}}, q_fix} + {{(HEAD_W-1){1'b0}}, !exact};
        if (zero4_reg)
            head_next = '0;
        else if (neg_x4_reg)
            head_next = FULL_TURN - ceil_q;
        else
            head_next = {{(HEAD_W-Q_W){1'b0}}, q_fix};
        if (head_next > HEAD_MAX)
            head_next = HEAD_MAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            r_reg      <= r_next;
            neg_x1_reg <= side.neg_x;
            zero1_reg  <= side.zero;
        end
        if (en[1])
        begin
            prod_reg   <= r_reg * DEG_NUM;
            neg_x2_reg <= neg_x1_reg;
            zero2_reg  <= zero1_reg;
        end
        if (en[2])
        begin
            t_reg      <= prod_reg[PROD_W-1:ANG_FRAC];
            q0_reg     <= qm[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
            frac3_reg  <= |prod_reg[ANG_FRAC-1:0];
            neg_x3_reg <= neg_x2_reg;
            zero3_reg  <= zero2_reg;
        end
        if (en[3])
        begin
            q4_reg     <= q0_reg;
            rem_reg    <= rem_next;
            neg_x4_reg <= neg_x3_reg;
            zero4_reg  <= zero3_reg;
            frac4_reg  <= frac3_reg;
        end
        if (en[4])
            head_reg <= head_next;
    end

    assign out_valid = v_reg[NS-1];
    assign heading   = head_reg;

endmodule
